### src/sis_pkg.sv
`default_nettype none

package sis_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int VAL_W         = 64;
    localparam int OP_W          = 3;
    localparam int IDX_W         = 5;
    localparam int TOT_W         = 6;
    localparam int LIM_W         = 6;

    localparam logic [VAL_W-1:0] ALL_ONES = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_CONTAINS = 3'd2,
        OP_FORGOT   = 3'd3,
        OP_TRIM     = 3'd4,
        OP_READ_DSC = 3'd5,
        OP_READ_ASC = 3'd6,
        OP_CLEAR    = 3'd7
    } op_t;

    // what a cell does with its span
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_PREV,
        CELL_NEXT,
        CELL_SET_LOW,
        CELL_SET_HIGH
    } cell_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_ADD_PLACE,
        S_ADD_MERGE,
        S_EVICT,
        S_REM_SCAN,
        S_REM_SPLIT,
        S_TRIM,
        S_READ,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic below;
        logic hit;
    } cell_flags_t;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [VAL_W-1:0] range_start;
        logic [VAL_W-1:0] range_end;
        logic [IDX_W-1:0] span_index;
    } cmd_item_t;

    typedef struct packed {
        logic             accepted;
        logic             found;
        logic [VAL_W-1:0] span_start;
        logic [VAL_W-1:0] span_end;
        logic [TOT_W-1:0] span_total;
        logic [VAL_W-1:0] lowest_value;
        logic [VAL_W-1:0] highest_value;
        logic             has_forgotten;
        logic [VAL_W-1:0] forgotten_upto;
    } rsp_item_t;

endpackage

`default_nettype wire

### src/sis_chan_if.sv
`default_nettype none

interface sis_chan_if #(
    parameter type item_t = logic
) ();
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/sis_cell.sv
`default_nettype none

module sis_cell (
    input  wire                        clk,
    input  sis_pkg::cell_cmd_t         cmd,
    input  wire [sis_pkg::VAL_W-1:0]   bus_low,
    input  wire [sis_pkg::VAL_W-1:0]   bus_high,
    input  wire [sis_pkg::VAL_W-1:0]   probe,
    input  wire [sis_pkg::VAL_W-1:0]   prev_low,
    input  wire [sis_pkg::VAL_W-1:0]   prev_high,
    input  wire [sis_pkg::VAL_W-1:0]   next_low,
    input  wire [sis_pkg::VAL_W-1:0]   next_high,
    output logic [sis_pkg::VAL_W-1:0]  low,
    output logic [sis_pkg::VAL_W-1:0]  high,
    output sis_pkg::cell_flags_t       flags
);

    logic [sis_pkg::VAL_W-1:0] low_reg;
    logic [sis_pkg::VAL_W-1:0] high_reg;

    // span storage, moved by the sequencer one place at a time
    always_ff @(posedge clk)
    begin
        case (cmd)
            sis_pkg::CELL_LOAD:
            begin
                low_reg  <= bus_low;
                high_reg <= bus_high;
            end
            sis_pkg::CELL_PREV:
            begin
                low_reg  <= prev_low;
                high_reg <= prev_high;
            end
            sis_pkg::CELL_NEXT:
            begin
                low_reg  <= next_low;
                high_reg <= next_high;
            end
            sis_pkg::CELL_SET_LOW:  low_reg  <= bus_low;
            sis_pkg::CELL_SET_HIGH: high_reg <= bus_high;
            default:
            begin
                low_reg  <= low_reg;
                high_reg <= high_reg;
            end
        endcase
    end

    assign low  = low_reg;
    assign high = high_reg;

    // span lies wholly below probe without touching it; probe inside span
    assign flags.below = (probe != '0) && (high_reg < (probe - 1'b1));
    assign flags.hit   = (probe >= low_reg) && (probe <= high_reg);

endmodule

`default_nettype wire

### src/sorted_interval_set_top.sv
`default_nettype none

// channel  dir  payload                                   handshake
// cmd      in   opcode, range_start, range_end, span_index valid/ready
// rsp      out  accepted .. forgotten_upto                 valid/ready
// cfg      in   span_limit (6 bits)                        cfg_wr_en, no ready
//
// one item at a time; cmd is ready only while the sequencer is idle
// add: place or merge, fold in each touching span that follows, evict over the limit
// trim drops spans one at a time; remove walks the table span by span
// the cell row shifts one place per cycle on each drop, insert or split
// reset clears count, eviction mark and limit; span storage holds no reset
// a finished result waits in the output register while rsp is stalled

module sorted_interval_set_top #(
    parameter int TABLE_DEPTH = sis_pkg::DEPTH_DEFAULT
) (
    input  wire                       clk,
    input  wire                       rst_n,
    sis_chan_if.sink                  cmd,
    sis_chan_if.source                rsp,
    input  wire                       cfg_wr_en,
    input  wire [sis_pkg::LIM_W-1:0]  cfg_wr_data
);

    localparam int NC = TABLE_DEPTH + 1;
    localparam int CW = $clog2(NC + 1);
    localparam int XW = (CW > sis_pkg::LIM_W) ? CW : sis_pkg::LIM_W;
    localparam int VW = sis_pkg::VAL_W;

    sis_pkg::state_t           state_reg, state_next;
    sis_pkg::op_t              op_reg, op_next;
    logic [VW-1:0]             a_reg, a_next;
    logic [VW-1:0]             b_reg, b_next;
    logic [sis_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]             cur_reg, cur_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [VW-1:0]             hi_acc_reg, hi_acc_next;
    logic                      flag_reg, flag_next;
    logic [VW-1:0]             mark_reg, mark_next;
    logic [sis_pkg::LIM_W-1:0] limit_reg;
    logic                      acc_reg, acc_next;
    logic                      fnd_reg, fnd_next;
    logic [VW-1:0]             rs_reg, rs_next;
    logic [VW-1:0]             re_reg, re_next;
    logic                      out_valid_reg, out_valid_next;
    sis_pkg::rsp_item_t        out_item_reg, out_item_next;

    sis_pkg::cell_cmd_t        cell_cmd [NC];
    logic [VW-1:0]             cell_low [NC];
    logic [VW-1:0]             cell_high [NC];
    sis_pkg::cell_flags_t      cell_flags [NC];
    logic [VW-1:0]             bus_low, bus_high;
    logic [CW-1:0]             sel_idx;
    logic [VW-1:0]             sel_low, sel_high;
    logic [CW-1:0]             lim_eff;
    logic [CW-1:0]             first_keep;
    logic                      hit_any;
    logic [XW-1:0]             idx_x, cnt_x;

    // row of cells
    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        logic [VW-1:0] pl, ph, nl, nh;
        if (k == 0)
        begin : g_first
            assign pl = '0;
            assign ph = '0;
        end
        else
        begin : g_mid
            assign pl = cell_low[k-1];
            assign ph = cell_high[k-1];
        end
        if (k == NC - 1)
        begin : g_last
            assign nl = '0;
            assign nh = '0;
        end
        else
        begin : g_more
            assign nl = cell_low[k+1];
            assign nh = cell_high[k+1];
        end
        sis_cell u_cell (
            .clk       (clk),
            .cmd       (cell_cmd[k]),
            .bus_low   (bus_low),
            .bus_high  (bus_high),
            .probe     (a_reg),
            .prev_low  (pl),
            .prev_high (ph),
            .next_low  (nl),
            .next_high (nh),
            .low       (cell_low[k]),
            .high      (cell_high[k]),
            .flags     (cell_flags[k])
        );
    end

    // read port into the row
    always_comb
    begin
        sel_low  = '0;
        sel_high = '0;
        for (int k = 0; k < NC; k++)
        begin
            if (sel_idx == CW'(k))
            begin
                sel_low  = sel_low | cell_low[k];
                sel_high = sel_high | cell_high[k];
            end
        end
    end

    // insertion point for add and contains hit
    always_comb
    begin
        first_keep = cnt_reg;
        hit_any    = 1'b0;
        for (int k = NC - 1; k >= 0; k--)
        begin
            if ((CW'(k) < cnt_reg) && !cell_flags[k].below)
            begin
                first_keep = CW'(k);
            end
        end
        for (int k = 0; k < NC; k++)
        begin
            if ((CW'(k) < cnt_reg) && cell_flags[k].hit)
            begin
                hit_any = 1'b1;
            end
        end
    end

    // effective span limit
    always_comb
    begin
        if ((limit_reg == '0) || (XW'(limit_reg) > XW'(TABLE_DEPTH)))
        begin
            lim_eff = CW'(TABLE_DEPTH);
        end
        else
        begin
            lim_eff = CW'(limit_reg);
        end
    end

    assign idx_x = XW'(idx_reg);
    assign cnt_x = XW'(cnt_reg);

    assign cmd.ready   = (state_reg == sis_pkg::S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    // sequencer
    always_comb
    begin
        logic [VW-1:0] nlo, nhi;
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        hi_acc_next    = hi_acc_reg;
        flag_next      = flag_reg;
        mark_next      = mark_reg;
        acc_next       = acc_reg;
        fnd_next       = fnd_reg;
        rs_next        = rs_reg;
        re_next        = re_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        bus_low        = '0;
        bus_high       = '0;
        sel_idx        = cur_reg;
        nlo            = '0;
        nhi            = '0;
        for (int k = 0; k < NC; k++)
        begin
            cell_cmd[k] = sis_pkg::CELL_HOLD;
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sis_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = sis_pkg::op_t'(cmd.payload.opcode);
                    a_next     = cmd.payload.range_start;
                    b_next     = cmd.payload.range_end;
                    idx_next   = cmd.payload.span_index;
                    state_next = sis_pkg::S_START;
                end
            end

            sis_pkg::S_START:
            begin
                acc_next   = 1'b1;
                fnd_next   = 1'b0;
                rs_next    = '0;
                re_next    = '0;
                state_next = sis_pkg::S_FINISH;
                case (op_reg)
                    sis_pkg::OP_ADD:
                    begin
                        if (a_reg > b_reg)
                        begin
                            acc_next = 1'b0;
                        end
                        else
                        begin
                            cur_next   = first_keep;
                            state_next = sis_pkg::S_ADD_PLACE;
                        end
                    end
                    sis_pkg::OP_REMOVE:
                    begin
                        if (a_reg > b_reg)
                        begin
                            acc_next = 1'b0;
                        end
                        else
                        begin
                            cur_next   = '0;
                            state_next = sis_pkg::S_REM_SCAN;
                        end
                    end
                    sis_pkg::OP_CONTAINS: fnd_next = hit_any;
                    sis_pkg::OP_FORGOT:   fnd_next = flag_reg && (a_reg <= mark_reg);
                    sis_pkg::OP_TRIM:     state_next = sis_pkg::S_TRIM;
                    sis_pkg::OP_READ_DSC,
                    sis_pkg::OP_READ_ASC:
                    begin
                        if (idx_x >= cnt_x)
                        begin
                            acc_next = 1'b0;
                        end
                        else
                        begin
                            if (op_reg == sis_pkg::OP_READ_DSC)
                            begin
                                cur_next = CW'(cnt_x - XW'(1) - idx_x);
                            end
                            else
                            begin
                                cur_next = CW'(idx_x);
                            end
                            state_next = sis_pkg::S_READ;
                        end
                    end
                    sis_pkg::OP_CLEAR:    cnt_next = '0;
                    default:              cnt_next = cnt_reg;
                endcase
            end

            // insert a new span or open a merge at the insertion point
            sis_pkg::S_ADD_PLACE:
            begin
                sel_idx = cur_reg;
                if ((cur_reg == cnt_reg) ||
                    ((b_reg != sis_pkg::ALL_ONES) && ((b_reg + 1'b1) < sel_low)))
                begin
                    for (int k = 0; k < NC; k++)
                    begin
                        if (CW'(k) > cur_reg)
                        begin
                            cell_cmd[k] = sis_pkg::CELL_PREV;
                        end
                        else if (CW'(k) == cur_reg)
                        begin
                            cell_cmd[k] = sis_pkg::CELL_LOAD;
                        end
                    end
                    bus_low  = a_reg;
                    bus_high = b_reg;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    nlo = (sel_low < a_reg) ? sel_low : a_reg;
                    nhi = (sel_high > b_reg) ? sel_high : b_reg;
                    for (int k = 0; k < NC; k++)
                    begin
                        if (CW'(k) == cur_reg)
                        begin
                            cell_cmd[k] = sis_pkg::CELL_LOAD;
                        end
                    end
                    bus_low     = nlo;
                    bus_high    = nhi;
                    hi_acc_next = nhi;
                    state_next  = sis_pkg::S_ADD_MERGE;
                end
                if (state_next == sis_pkg::S_ADD_PLACE)
                begin
                    state_next = sis_pkg::S_EVICT;
                end
            end

            // fold following spans into the merged one, one per cycle
            sis_pkg::S_ADD_MERGE:
            begin
                sel_idx = cur_reg + 1'b1;
                if (((cur_reg + 1'b1) < cnt_reg) &&
                    ((sel_low <= hi_acc_reg) ||
                     ((hi_acc_reg != sis_pkg::ALL_ONES) && (sel_low == hi_acc_reg + 1'b1))))
                begin
                    nhi = (sel_high > hi_acc_reg) ? sel_high : hi_acc_reg;
                    for (int k = 0; k < NC; k++)
                    begin
                        if (CW'(k) > cur_reg)
                        begin
                            cell_cmd[k] = sis_pkg::CELL_NEXT;
                        end
                        else if (CW'(k) == cur_reg)
                        begin
                            cell_cmd[k] = sis_pkg::CELL_SET_HIGH;
                        end
                    end
                    bus_high    = nhi;
                    hi_acc_next = nhi;
                    cnt_next    = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = sis_pkg::S_EVICT;
                end
            end

            // drop lowest spans over the limit, raising the mark
            sis_pkg::S_EVICT:
            begin
                if (cnt_reg > lim_eff)
                begin
                    for (int k = 0; k < NC; k++)
                    begin
                        cell_cmd[k] = sis_pkg::CELL_NEXT;
                    end
                    cnt_next = cnt_reg - 1'b1;
                    if (!flag_reg || (cell_high[0] > mark_reg))
                    begin
                        mark_next = cell_high[0];
                    end
                    flag_next = 1'b1;
                end
                else
                begin
                    state_next = sis_pkg::S_FINISH;
                end
            end

            // walk the table cutting spans against the removed range
            sis_pkg::S_REM_SCAN:
            begin
                sel_idx = cur_reg;
                if (cur_reg >= cnt_reg)
                begin
                    state_next = sis_pkg::S_FINISH;
                end
                else if ((sel_high < a_reg) || (sel_low > b_reg))
                begin
                    cur_next = cur_reg + 1'b1;
                end
                else if ((sel_low >= a_reg) && (sel_high <= b_reg))
                begin
                    for (int k = 0; k < NC; k++)
                    begin
                        if (CW'(k) >= cur_reg)
                        begin
                            cell_cmd[k] = sis_pkg::CELL_NEXT;
                        end
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
                else if ((sel_low < a_reg) && (sel_high > b_reg))
                begin
                    if (cnt_reg >= CW'(TABLE_DEPTH))
                    begin
                        acc_next   = 1'b0;
                        state_next = sis_pkg::S_FINISH;
                    end
                    else
                    begin
                        for (int k = 0; k < NC; k++)
                        begin
                            if (CW'(k) > cur_reg)
                            begin
                                cell_cmd[k] = sis_pkg::CELL_PREV;
                            end
                        end
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = sis_pkg::S_REM_SPLIT;
                    end
                end
                else
                begin
                    for (int k = 0; k < NC; k++)
                    begin
                        if (CW'(k) == cur_reg)
                        begin
                            cell_cmd[k] = (sel_low < a_reg) ? sis_pkg::CELL_SET_HIGH
                                                            : sis_pkg::CELL_SET_LOW;
                        end
                    end
                    bus_low  = b_reg + 1'b1;
                    bus_high = a_reg - 1'b1;
                    cur_next = cur_reg + 1'b1;
                end
            end

            // finish a split: both copies get their new edges
            sis_pkg::S_REM_SPLIT:
            begin
                for (int k = 0; k < NC; k++)
                begin
                    if (CW'(k) == cur_reg)
                    begin
                        cell_cmd[k] = sis_pkg::CELL_SET_HIGH;
                    end
                    else if (CW'(k) == cur_reg + 1'b1)
                    begin
                        cell_cmd[k] = sis_pkg::CELL_SET_LOW;
                    end
                end
                bus_low    = b_reg + 1'b1;
                bus_high   = a_reg - 1'b1;
                state_next = sis_pkg::S_FINISH;
            end

            // drop spans at or below the trim value, then cut the first
            sis_pkg::S_TRIM:
            begin
                if ((cnt_reg != '0) && (cell_high[0] <= a_reg))
                begin
                    for (int k = 0; k < NC; k++)
                    begin
                        cell_cmd[k] = sis_pkg::CELL_NEXT;
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    if ((cnt_reg != '0) && (cell_low[0] <= a_reg))
                    begin
                        cell_cmd[0] = sis_pkg::CELL_SET_LOW;
                        bus_low     = a_reg + 1'b1;
                    end
                    state_next = sis_pkg::S_FINISH;
                end
            end

            sis_pkg::S_READ:
            begin
                sel_idx    = cur_reg;
                rs_next    = sel_low;
                re_next    = sel_high;
                state_next = sis_pkg::S_FINISH;
            end

            // build the result once the output register is free
            sis_pkg::S_FINISH:
            begin
                sel_idx = cnt_reg - 1'b1;
                if (!out_valid_reg || rsp.ready)
                begin
                    out_item_next.accepted       = acc_reg;
                    out_item_next.found          = fnd_reg;
                    out_item_next.span_start     = rs_reg;
                    out_item_next.span_end       = re_reg;
                    out_item_next.span_total     = sis_pkg::TOT_W'(cnt_reg);
                    out_item_next.lowest_value   = (cnt_reg != '0) ? cell_low[0] : '0;
                    out_item_next.highest_value  = (cnt_reg != '0) ? sel_high : '0;
                    out_item_next.has_forgotten  = flag_reg;
                    out_item_next.forgotten_upto = mark_reg;
                    out_valid_next               = 1'b1;
                    state_next                   = sis_pkg::S_IDLE;
                end
            end

            default: state_next = sis_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sis_pkg::S_IDLE;
            cnt_reg       <= '0;
            cur_reg       <= '0;
            flag_reg      <= 1'b0;
            mark_reg      <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
            flag_reg      <= flag_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // item payload and result holding
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        idx_reg      <= idx_next;
        hi_acc_reg   <= hi_acc_next;
        acc_reg      <= acc_next;
        fnd_reg      <= fnd_next;
        rs_reg       <= rs_next;
        re_reg       <= re_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

### bench/sorted_interval_set_top_test.sv
`timescale 1ns / 1ps

module sorted_interval_set_top_test;
    import sis_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;

    // span table model and its result queue
    class span_table_board;
        logic [VAL_W-1:0] lo_q[$];
        logic [VAL_W-1:0] hi_q[$];
        bit               evicted;
        logic [VAL_W-1:0] evict_upto;
        int unsigned      limit_reg;
        rsp_item_t        pending[$];
        int               errors;
        int               checked;

        function void clear_all();
            lo_q.delete();
            hi_q.delete();
            evicted = 0;
            evict_upto = '0;
            limit_reg = 0;
            pending.delete();
        endfunction

        function void drop_spans(int at, int n);
            for (int k = 0; k < n; k++)
            begin
                lo_q.delete(at);
                hi_q.delete(at);
            end
        endfunction

        function void merge_span(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
            int i;
            int j;
            int lim;
            int n;
            i = 0;
            while (i < lo_q.size() && lo > 0 && hi_q[i] < lo - 1)
                i++;
            if (i == lo_q.size() || (hi != ALL_ONES && hi + 1 < lo_q[i]))
            begin
                lo_q.insert(i, lo);
                hi_q.insert(i, hi);
            end
            else
            begin
                if (lo_q[i] < lo)
                    lo = lo_q[i];
                j = i;
                while (j < lo_q.size() &&
                       (lo_q[j] <= hi || (hi != ALL_ONES && lo_q[j] == hi + 1)))
                begin
                    if (hi_q[j] > hi)
                        hi = hi_q[j];
                    j++;
                end
                lo_q[i] = lo;
                hi_q[i] = hi;
                if (j > i + 1)
                    drop_spans(i + 1, j - i - 1);
            end
            lim = (limit_reg == 0 || limit_reg > DEPTH) ? DEPTH : limit_reg;
            if (lo_q.size() > lim)
            begin
                n = lo_q.size() - lim;
                if (!evicted || hi_q[n-1] > evict_upto)
                begin
                    evict_upto = hi_q[n-1];
                    evicted = 1;
                end
                drop_spans(0, n);
            end
        endfunction

        function bit cut_span(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
            int i;
            i = 0;
            while (i < lo_q.size())
            begin
                if (hi_q[i] < lo || lo_q[i] > hi)
                    i++;
                else if (lo_q[i] >= lo && hi_q[i] <= hi)
                    drop_spans(i, 1);
                else if (lo_q[i] < lo && hi_q[i] > hi)
                begin
                    if (lo_q.size() >= DEPTH)
                        return 0;
                    lo_q.insert(i + 1, hi + 1);
                    hi_q.insert(i + 1, hi_q[i]);
                    hi_q[i] = lo - 1;
                    return 1;
                end
                else
                begin
                    if (lo_q[i] < lo)
                        hi_q[i] = lo - 1;
                    else
                        lo_q[i] = hi + 1;
                    i++;
                end
            end
            return 1;
        endfunction

        // note an accepted command item
        function void note_cmd(cmd_item_t c);
            rsp_item_t r;
            int k;
            r = '0;
            r.accepted = 1;
            case (op_t'(c.opcode))
                OP_ADD:
                    if (c.range_start > c.range_end) r.accepted = 0;
                    else merge_span(c.range_start, c.range_end);
                OP_REMOVE:
                    if (c.range_start > c.range_end) r.accepted = 0;
                    else r.accepted = cut_span(c.range_start, c.range_end);
                OP_CONTAINS:
                    foreach (lo_q[q])
                        if (c.range_start >= lo_q[q] && c.range_start <= hi_q[q])
                            r.found = 1;
                OP_FORGOT:
                    r.found = evicted && c.range_start <= evict_upto;
                OP_TRIM:
                begin
                    k = 0;
                    while (k < lo_q.size() && hi_q[k] <= c.range_start)
                        k++;
                    drop_spans(0, k);
                    if (lo_q.size() > 0 && lo_q[0] <= c.range_start)
                        lo_q[0] = c.range_start + 1;
                end
                OP_READ_DSC, OP_READ_ASC:
                    if (c.span_index >= lo_q.size())
                        r.accepted = 0;
                    else
                    begin
                        k = (c.opcode == OP_READ_DSC) ?
                            lo_q.size() - 1 - c.span_index : c.span_index;
                        r.span_start = lo_q[k];
                        r.span_end = hi_q[k];
                    end
                default:
                begin
                    lo_q.delete();
                    hi_q.delete();
                end
            endcase
            r.span_total = TOT_W'(lo_q.size());
            r.lowest_value = lo_q.size() ? lo_q[0] : '0;
            r.highest_value = lo_q.size() ? hi_q[lo_q.size()-1] : '0;
            r.has_forgotten = evicted;
            r.forgotten_upto = evict_upto;
            pending.push_back(r);
        endfunction

        // compare one result item with the oldest expectation
        function void check_rsp(rsp_item_t got);
            rsp_item_t exp_r;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.accepted !== exp_r.accepted)
            begin
                $display("%0t accepted exp %0d got %0d", $time, exp_r.accepted, got.accepted);
                errors++;
            end
            if (got.found !== exp_r.found)
            begin
                $display("%0t found exp %0d got %0d", $time, exp_r.found, got.found);
                errors++;
            end
            if (got.span_start !== exp_r.span_start)
            begin
                $display("%0t span_start exp %h got %h", $time, exp_r.span_start,
                         got.span_start);
                errors++;
            end
            if (got.span_end !== exp_r.span_end)
            begin
                $display("%0t span_end exp %h got %h", $time, exp_r.span_end, got.span_end);
                errors++;
            end
            if (got.span_total !== exp_r.span_total)
            begin
                $display("%0t span_total exp %0d got %0d", $time, exp_r.span_total,
                         got.span_total);
                errors++;
            end
            if (got.lowest_value !== exp_r.lowest_value)
            begin
                $display("%0t lowest_value exp %h got %h", $time, exp_r.lowest_value,
                         got.lowest_value);
                errors++;
            end
            if (got.highest_value !== exp_r.highest_value)
            begin
                $display("%0t highest_value exp %h got %h", $time, exp_r.highest_value,
                         got.highest_value);
                errors++;
            end
            if (got.has_forgotten !== exp_r.has_forgotten)
            begin
                $display("%0t has_forgotten exp %0d got %0d", $time, exp_r.has_forgotten,
                         got.has_forgotten);
                errors++;
            end
            if (got.forgotten_upto !== exp_r.forgotten_upto)
            begin
                $display("%0t forgotten_upto exp %h got %h", $time, exp_r.forgotten_upto,
                         got.forgotten_upto);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [LIM_W-1:0] cfg_wr_data;

    sis_chan_if #(.item_t(cmd_item_t)) cmd_ch ();
    sis_chan_if #(.item_t(rsp_item_t)) rsp_ch ();

    sorted_interval_set_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch.sink),
        .rsp         (rsp_ch.source),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    span_table_board board;
    int  sent_items;
    bit  hold_rsp;
    bit  stall_mode;
    int  base_mode;

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("sorted_interval_set_top verification failed");
        $finish;
    end

    // result side: stall pattern plus long hold-off
    initial
    begin
        rsp_ch.ready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                board.check_rsp(rsp_ch.payload);
            if (hold_rsp)
                rsp_ch.ready <= 0;
            else if (!stall_mode)
                rsp_ch.ready <= 1;
            else
                rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // one command item; holds valid until accepted
    task automatic send_cmd(op_t op, logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                            logic [IDX_W-1:0] idx);
        cmd_item_t c;
        c.opcode = op;
        c.range_start = a;
        c.range_end = b;
        c.span_index = idx;
        cmd_ch.valid <= 1;
        cmd_ch.payload <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        board.note_cmd(c);
        sent_items++;
    endtask

    task automatic idle_cmd(int n);
        cmd_ch.valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        cmd_ch.valid <= 0;
        while (board.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic set_limit(int unsigned v);
        cfg_wr_en <= 1;
        cfg_wr_data <= LIM_W'(v);
        @(posedge clk);
        cfg_wr_en <= 0;
        board.limit_reg = v;
    endtask

    // value mostly near a small working window so spans overlap and touch; some near the extremes
    function automatic logic [VAL_W-1:0] pick_val();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return VAL_W'(base_mode + $urandom_range(0, 200));
        else if (sel == 7)
            return ALL_ONES - $urandom_range(0, 200);
        else if (sel == 8)
            return VAL_W'($urandom_range(0, 200));
        else
            return {$urandom, $urandom};
    endfunction

    task automatic random_cmd();
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic [IDX_W-1:0] idx;
        int sel;
        sel = $urandom_range(0, 99);
        idx = IDX_W'($urandom);
        a = pick_val();
        b = a + $urandom_range(0, 8);
        if (b < a)
            b = ALL_ONES;
        if ($urandom_range(0, 30) == 0)
            b = {$urandom, $urandom};
        if (sel < 45)
            send_cmd(OP_ADD, a, b, idx);
        else if (sel < 60)
            send_cmd(OP_REMOVE, a, b, idx);
        else if (sel < 68)
            send_cmd(OP_CONTAINS, a, b, idx);
        else if (sel < 74)
            send_cmd(OP_FORGOT, a, b, idx);
        else if (sel < 77)
            send_cmd(OP_TRIM, a - $urandom_range(0, 100), b, idx);
        else if (sel < 88)
            send_cmd(OP_READ_DSC, a, b, idx);
        else if (sel < 99)
            send_cmd(OP_READ_ASC, a, b, idx);
        else
            send_cmd(OP_CLEAR, a, b, idx);
    endtask

    task automatic random_phase(int count);
        int burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && count > 0)
            begin
                random_cmd();
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cmd($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        int limits[6];
        board = new();
        board.clear_all();
        board.errors = 0;
        board.checked = 0;
        sent_items = 0;
        hold_rsp = 0;
        stall_mode = 0;
        base_mode = 1000;
        cmd_ch.valid = 0;
        cmd_ch.payload = '0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every opcode, special cases
        send_cmd(OP_READ_ASC, 0, 0, 0);
        send_cmd(OP_ADD, 10, 5, 0);
        send_cmd(OP_ADD, ALL_ONES - 3, ALL_ONES, 0);
        send_cmd(OP_ADD, ALL_ONES - 10, ALL_ONES - 4, 0);
        send_cmd(OP_ADD, 0, 0, 0);
        send_cmd(OP_ADD, 1, 1, 0);
        send_cmd(OP_ADD, 20, 30, 0);
        send_cmd(OP_ADD, 32, 40, 0);
        send_cmd(OP_ADD, 31, 31, 0);
        send_cmd(OP_CONTAINS, 25, 0, 0);
        send_cmd(OP_CONTAINS, 50, 0, 0);
        send_cmd(OP_REMOVE, 25, 26, 0);
        send_cmd(OP_REMOVE, 9, 5, 0);
        send_cmd(OP_READ_DSC, 0, 0, 0);
        send_cmd(OP_READ_ASC, 0, 0, 1);
        send_cmd(OP_READ_ASC, 0, 0, 31);
        send_cmd(OP_REMOVE, 0, ALL_ONES - 5, 0);
        send_cmd(OP_FORGOT, 0, 0, 0);
        send_cmd(OP_TRIM, ALL_ONES, 0, 0);
        send_cmd(OP_ADD, 0, ALL_ONES, 0);
        send_cmd(OP_TRIM, 100, 0, 0);
        send_cmd(OP_CLEAR, ALL_ONES, ALL_ONES, 5'h1f);
        drain();

        // full table then a split that the full table refuses, and eviction past the table depth
        set_limit(0);
        for (int k = 0; k < DEPTH; k++)
            send_cmd(OP_ADD, VAL_W'(100 * k), VAL_W'(100 * k + 50), 0);
        send_cmd(OP_REMOVE, 110, 120, 0);
        send_cmd(OP_ADD, 3300, 3310, 0);
        send_cmd(OP_FORGOT, 50, 0, 0);
        send_cmd(OP_FORGOT, 51, 0, 0);
        drain();

        // random phases over several limits; long hold-off in the first
        limits = '{1, 32, 63, 3, 0, 8};
        stall_mode = 1;
        for (int p = 0; p < 6; p++)
        begin
            set_limit(limits[p]);
            base_mode = $urandom_range(0, 1) ? 1000 : $urandom;
            if (p == 0)
            begin
                hold_rsp = 1;
                fork
                    begin
                        repeat (300) @(posedge clk);
                        hold_rsp = 0;
                    end
                    random_phase(165);
                join
            end
            else
            begin
                stall_mode = (p % 2 == 1);
                random_phase(165);
            end
            drain();
        end

        $display("items sent %0d, results checked %0d", sent_items, board.checked);
        $display("limits 0,1,3,8,32,63 with split, eviction and all-ones cases");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("sorted_interval_set_top verification clean");
        else
            $display("sorted_interval_set_top verification failed");
        $finish;
    end
endmodule
